// ----- rtl/mtt_pkg.sv -----
`default_nettype none

package mtt_pkg;

   // table size; slot indices travel in 5 bits, so at most 32 slots are usable
   localparam int TIMER_SLOTS = 32;
   localparam int QUEUE_IDS   = 16;
   localparam int SLOT_CNT    = (TIMER_SLOTS < 32) ? TIMER_SLOTS : 32;
   localparam int SLOT_AW     = (SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1;
   localparam int SLOT_CW     = SLOT_AW + 1;

   // field widths
   localparam int OP_W   = 3;
   localparam int IDX_W  = 5;
   localparam int QID_W  = 4;
   localparam int BYTE_W = 8;
   localparam int TICK_W = 32;
   localparam int QD_W   = QID_W + BYTE_W;

   localparam logic [TICK_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

   // command queue between front and back
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

   // request op codes
   localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
   localparam logic [OP_W-1:0] OP_BIND  = 3'd2;
   localparam logic [OP_W-1:0] OP_ARM   = 3'd3;
   localparam logic [OP_W-1:0] OP_TICK  = 3'd4;

   // result kinds
   localparam logic RSP_ALLOC = 1'b0;
   localparam logic RSP_FIRED = 1'b1;

   typedef enum logic [2:0] {
      CMD_ALLOC,
      CMD_FREE,
      CMD_BIND,
      CMD_ARM,
      CMD_TICK
   } cmd_kind_type;

   typedef enum logic [1:0] {
      SLOT_FREE  = 2'd0,
      SLOT_ALLOC = 2'd1,
      SLOT_ARMED = 2'd2
   } slot_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_FLUSH
   } back_state_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [IDX_W-1:0]    index;
      logic [QID_W-1:0]    queue;
      logic [BYTE_W-1:0]   data;
      logic [TICK_W-1:0]   delay;
   } cmd_type;

endpackage

`default_nettype wire

// ----- rtl/mtt_ram.sv -----
`default_nettype none

module mtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/mtt_front.sv -----
`default_nettype none

module mtt_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [55:0]            req_tdata,
   input  wire logic [mtt_pkg::OP_W-1:0] req_tuser,
   input  wire logic                   q_full,
   output logic                        q_push,
   output mtt_pkg::cmd_type            q_cmd
);

   import mtt_pkg::*;

   logic [IDX_W-1:0]  f_index;
   logic [QID_W-1:0]  f_queue;
   logic [BYTE_W-1:0] f_data;
   logic [TICK_W-1:0] f_delay;
   logic              idx_ok;
   logic              qid_ok;
   logic              keep;
   cmd_kind_type      cmd_kind;
   logic              busy_ff;
   logic              busy_in;

   // unpack the word
   assign f_index = req_tdata[4:0];
   assign f_queue = req_tdata[8:5];
   assign f_data  = req_tdata[16:9];
   assign f_delay = req_tdata[48:17];

   assign idx_ok = {1'b0, f_index} < (IDX_W + 1)'(SLOT_CNT);
   assign qid_ok = {5'd0, f_queue} < (QID_W + 5)'(QUEUE_IDS);

   // classify: drop words that leave the table untouched
   always_comb begin
      keep     = 1'b0;
      cmd_kind = CMD_TICK;
      case (req_tuser)
         OP_ALLOC: begin
            keep     = 1'b1;
            cmd_kind = CMD_ALLOC;
         end
         OP_FREE: begin
            keep     = idx_ok;
            cmd_kind = CMD_FREE;
         end
         OP_BIND: begin
            keep     = idx_ok && qid_ok;
            cmd_kind = CMD_BIND;
         end
         OP_ARM: begin
            keep     = idx_ok;
            cmd_kind = CMD_ARM;
         end
         OP_TICK: begin
            keep     = 1'b1;
            cmd_kind = CMD_TICK;
         end
         default: begin
            keep     = 1'b0;
            cmd_kind = CMD_TICK;
         end
      endcase
   end

   assign q_cmd = {cmd_kind, f_index, f_queue, f_data, f_delay};

   // hold off for one cycle after reset
   assign busy_in = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign req_tready = !q_full && !busy_ff;
   assign q_push     = req_tvalid && req_tready && keep;

endmodule

`default_nettype wire

// ----- rtl/mtt_queue.sv -----
`default_nettype none

module mtt_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  mtt_pkg::cmd_type      push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output mtt_pkg::cmd_type      pop_cmd,
   output logic                  not_empty
);

   import mtt_pkg::*;

   cmd_type              store_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff;
   logic [CMDQ_AW-1:0]   wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff;
   logic [CMDQ_AW-1:0]   rd_ptr_in;
   logic [CMDQ_AW:0]     count_ff;
   logic [CMDQ_AW:0]     count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full      = count_ff == (CMDQ_AW + 1)'(CMDQ_DEPTH);
   assign not_empty = count_ff != '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_cmd   = store_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the word
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/mtt_back.sv -----
`default_nettype none

module mtt_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     cmd_valid,
   input  mtt_pkg::cmd_type              cmd,
   output logic                          cmd_pop,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [23:0]                   rsp_tdata,
   output logic                          rsp_tuser,
   output logic                          rsp_tlast
);

   import mtt_pkg::*;

   back_state_type     state_ff;
   back_state_type     state_in;

   logic [TICK_W-1:0]  tick_count_ff;
   logic [TICK_W-1:0]  tick_count_in;
   logic [TICK_W-1:0]  next_deadline_ff;
   logic [TICK_W-1:0]  next_deadline_in;
   slot_state_type     status_ff [SLOT_CNT];

   // status write port
   logic               st_we;
   logic [SLOT_AW-1:0] st_wa;
   slot_state_type     st_wd;

   // scan state
   logic [SLOT_CW-1:0] scan_cnt_ff;
   logic [SLOT_CW-1:0] scan_cnt_in;
   logic               rd_valid_ff;
   logic               rd_valid_in;
   logic [SLOT_AW-1:0] rd_slot_ff;
   logic [SLOT_AW-1:0] rd_slot_in;
   logic [TICK_W-1:0]  nxt_ff;
   logic [TICK_W-1:0]  nxt_in;
   logic               held_valid_ff;
   logic               held_valid_in;
   logic [SLOT_AW-1:0] held_slot_ff;
   logic [SLOT_AW-1:0] held_slot_in;
   logic [QD_W-1:0]    held_qd_ff;
   logic [QD_W-1:0]    held_qd_in;

   // output register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_kind_ff;
   logic               rsp_kind_in;
   logic [IDX_W-1:0]   rsp_index_ff;
   logic [IDX_W-1:0]   rsp_index_in;
   logic               rsp_ok_ff;
   logic               rsp_ok_in;
   logic [QD_W-1:0]    rsp_qd_ff;
   logic [QD_W-1:0]    rsp_qd_in;
   logic               rsp_last_ff;
   logic               rsp_last_in;

   // memories
   logic               dl_we;
   logic               qd_we;
   logic               rd_en;
   logic [SLOT_AW-1:0] rd_addr;
   logic [TICK_W-1:0]  dl_wdata;
   logic [TICK_W-1:0]  dl_rdata;
   logic [QD_W-1:0]    qd_rdata;

   logic               out_free;
   logic               take;
   logic [SLOT_AW-1:0] cmd_slot;
   logic [TICK_W-1:0]  tick_next;
   logic               start_scan;
   logic               issue;
   logic               armed;
   logic               fires;
   logic               stall;
   logic               advance;
   logic               flush_done;
   logic               free_found;
   logic [SLOT_AW-1:0] free_slot;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign cmd_slot  = cmd.index[SLOT_AW-1:0];
   assign tick_next = tick_count_ff + 1'b1;
   assign dl_wdata  = tick_count_ff + cmd.delay;
   assign take      = (state_ff == BK_IDLE) && cmd_valid
                      && ((cmd.kind != CMD_ALLOC) || out_free);
   assign cmd_pop   = take;
   assign start_scan = take && (cmd.kind == CMD_TICK) && !(next_deadline_ff > tick_next);

   // scan pipeline: one slot read per cycle unless stalled, data next cycle
   assign issue   = scan_cnt_ff < SLOT_CW'(SLOT_CNT);
   assign rd_addr = scan_cnt_ff[SLOT_AW-1:0];
   assign armed   = status_ff[rd_slot_ff] == SLOT_ARMED;
   assign fires   = armed && (dl_rdata <= tick_count_ff);
   assign stall   = rd_valid_ff && fires && held_valid_ff && !out_free;
   assign advance = (state_ff == BK_SCAN) && !stall;
   assign rd_en   = advance && issue;
   assign flush_done = !held_valid_ff || out_free;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = SLOT_CNT - 1; i >= 0; i--) begin
         if (status_ff[i] == SLOT_FREE) begin
            free_found = 1'b1;
            free_slot  = SLOT_AW'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (start_scan) begin
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (!issue && !rd_valid_ff) begin
               state_in = BK_FLUSH;
            end
         end
         BK_FLUSH: begin
            if (flush_done) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      tick_count_in    = tick_count_ff;
      next_deadline_in = next_deadline_ff;
      st_we            = 1'b0;
      st_wa            = cmd_slot;
      st_wd            = SLOT_FREE;
      dl_we            = 1'b0;
      qd_we            = 1'b0;
      scan_cnt_in      = scan_cnt_ff;
      rd_valid_in      = rd_valid_ff;
      rd_slot_in       = rd_slot_ff;
      nxt_in           = nxt_ff;
      held_valid_in    = held_valid_ff;
      held_slot_in     = held_slot_ff;
      held_qd_in       = held_qd_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_kind_in      = rsp_kind_ff;
      rsp_index_in     = rsp_index_ff;
      rsp_ok_in        = rsp_ok_ff;
      rsp_qd_in        = rsp_qd_ff;
      rsp_last_in      = rsp_last_ff;
      case (state_ff)
         BK_IDLE: begin
            if (take) begin
               case (cmd.kind)
                  CMD_ALLOC: begin
                     st_we        = free_found;
                     st_wa        = free_slot;
                     st_wd        = SLOT_ALLOC;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = RSP_ALLOC;
                     rsp_index_in = free_found ? IDX_W'(free_slot) : '0;
                     rsp_ok_in    = free_found;
                     rsp_qd_in    = '0;
                     rsp_last_in  = 1'b1;
                  end
                  CMD_FREE: begin
                     st_we = 1'b1;
                     st_wd = SLOT_FREE;
                  end
                  CMD_BIND: begin
                     qd_we = 1'b1;
                  end
                  CMD_ARM: begin
                     dl_we = 1'b1;
                     st_we = 1'b1;
                     st_wd = SLOT_ARMED;
                     if (next_deadline_ff > dl_wdata) begin
                        next_deadline_in = dl_wdata;
                     end
                  end
                  CMD_TICK: begin
                     tick_count_in = tick_next;
                     scan_cnt_in   = '0;
                     rd_valid_in   = 1'b0;
                     nxt_in        = ALL_ONES;
                     held_valid_in = 1'b0;
                  end
                  default: begin
                     st_we = 1'b0;
                  end
               endcase
            end
         end
         BK_SCAN: begin
            if (advance) begin
               if (rd_valid_ff) begin
                  if (fires) begin
                     st_we = 1'b1;
                     st_wa = rd_slot_ff;
                     st_wd = SLOT_ALLOC;
                     // release the previous hit, now known not to be the last
                     if (held_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = RSP_FIRED;
                        rsp_index_in = IDX_W'(held_slot_ff);
                        rsp_ok_in    = 1'b0;
                        rsp_qd_in    = held_qd_ff;
                        rsp_last_in  = 1'b0;
                     end
                     held_valid_in = 1'b1;
                     held_slot_in  = rd_slot_ff;
                     held_qd_in    = qd_rdata;
                  end else if (armed && (nxt_ff > dl_rdata)) begin
                     nxt_in = dl_rdata;
                  end
               end
               rd_valid_in = issue;
               rd_slot_in  = rd_addr;
               if (issue) begin
                  scan_cnt_in = scan_cnt_ff + 1'b1;
               end
            end
         end
         BK_FLUSH: begin
            if (flush_done) begin
               next_deadline_in = nxt_ff;
               if (held_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = RSP_FIRED;
                  rsp_index_in = IDX_W'(held_slot_ff);
                  rsp_ok_in    = 1'b0;
                  rsp_qd_in    = held_qd_ff;
                  rsp_last_in  = 1'b1;
               end
               held_valid_in = 1'b0;
            end
         end
         default: begin
            st_we = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= BK_IDLE;
         tick_count_ff    <= '0;
         next_deadline_ff <= ALL_ONES;
         scan_cnt_ff      <= '0;
         rd_valid_ff      <= 1'b0;
         held_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         tick_count_ff    <= tick_count_in;
         next_deadline_ff <= next_deadline_in;
         scan_cnt_ff      <= scan_cnt_in;
         rd_valid_ff      <= rd_valid_in;
         held_valid_ff    <= held_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // slot status
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_CNT; i++) begin
            status_ff[i] <= SLOT_FREE;
         end
      end else if (st_we) begin
         status_ff[st_wa] <= st_wd;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_slot_ff   <= rd_slot_in;
      nxt_ff       <= nxt_in;
      held_slot_ff <= held_slot_in;
      held_qd_ff   <= held_qd_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_index_ff <= rsp_index_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_qd_ff    <= rsp_qd_in;
      rsp_last_ff  <= rsp_last_in;
   end

   mtt_ram #(
      .WIDTH (TICK_W),
      .DEPTH (SLOT_CNT)
   ) u_deadline_ram (
      .clock   (clock),
      .wr_en   (dl_we),
      .wr_addr (cmd_slot),
      .wr_data (dl_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (dl_rdata)
   );

   // queue id in the low bits, data byte above
   mtt_ram #(
      .WIDTH (QD_W),
      .DEPTH (SLOT_CNT)
   ) u_target_ram (
      .clock   (clock),
      .wr_en   (qd_we),
      .wr_addr (cmd_slot),
      .wr_data ({cmd.data, cmd.queue}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (qd_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'd0, rsp_qd_ff, rsp_ok_ff, rsp_index_ff};

endmodule

`default_nettype wire

// ----- rtl/multi_timer_table_top.sv -----
`default_nettype none

// Channel  Ports   Word
// -------  ------  -------------------------------------------------------------
// request  req_*   tuser op; tdata timer_index, dest_queue, event_data, delay
// result   rsp_*   tuser kind; tdata out_index, alloc_ok, out_queue, out_data;
//                  tlast last
//
// Alloc, free, bind, arm and a tick that stays short of the earliest deadline
// are handled straight from idle. A tick that reaches the earliest deadline scans
// the slot table through the deadline RAM one slot per cycle while no result
// stall holds it.
// Requests queue in a four-word command queue; req_tready drops only when it
// is full, and for one cycle after reset. Reset is synchronous and frees all
// slots at once; a full result register stalls the scan and alloc.

module multi_timer_table_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,  // timer_index, dest_queue, event_data, delay
   input  wire logic [2:0]  req_tuser,  // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // out_index, alloc_ok, out_queue, out_data
   output logic             rsp_tuser,  // kind
   output logic             rsp_tlast
);

   import mtt_pkg::*;

   cmd_type push_cmd;
   cmd_type pop_cmd;
   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_not_empty;

   mtt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   mtt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_cmd   (pop_cmd),
      .not_empty (q_not_empty)
   );

   mtt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_not_empty),
      .cmd        (pop_cmd),
      .cmd_pop    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- bench/multi_timer_table_top_tb.sv -----
`timescale 1ns / 1ps

module multi_timer_table_top_tb;
   import mtt_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = SLOT_CNT + 8;
   localparam int MAX_GAP         = 20;

   // op codes the block ignores
   localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
   localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

   typedef struct packed {
      logic              kind;
      logic [IDX_W-1:0]  index;
      logic              ok;
      logic [QID_W-1:0]  queue;
      logic [BYTE_W-1:0] data;
      logic              last;
   } timer_answer_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;   // timer_index, dest_queue, event_data, delay
   logic [2:0]  req_tuser  = '0;   // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // out_index, alloc_ok, out_queue, out_data
   logic        rsp_tuser;         // kind
   logic        rsp_tlast;

   // predicted table state
   logic [TICK_W-1:0] tick_now;
   logic [TICK_W-1:0] earliest_due;
   slot_state_type    slot_state [SLOT_CNT];
   logic [TICK_W-1:0] slot_due   [SLOT_CNT];
   logic [QID_W-1:0]  slot_queue [SLOT_CNT];
   logic [BYTE_W-1:0] slot_byte  [SLOT_CNT];
   bit                slot_bound [SLOT_CNT];

   timer_answer_type timer_answers_due [$];

   int failures       = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int idle_cycles    = 0;
   int hold_left      = 0;
   bit hold_toggle    = 1'b0;
   bit hold_seen      = 1'b0;

   multi_timer_table_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // advance the predicted table by one accepted word and queue its answers
   task automatic apply_timer_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                 input logic [QID_W-1:0] q, input logic [BYTE_W-1:0] d,
                                 input logic [TICK_W-1:0] delay);
      logic [TICK_W-1:0] new_due;
      logic [TICK_W-1:0] next_due;
      int                fired [$];
      timer_answer_type  ans;
      ans = '0;
      case (op)
         OP_ALLOC: begin
            ans.kind = RSP_ALLOC;
            for (int i = 0; i < SLOT_CNT; i++) begin
               if (slot_state[i] == SLOT_FREE && !ans.ok) begin
                  slot_state[i] = SLOT_ALLOC;
                  ans.ok        = 1'b1;
                  ans.index     = IDX_W'(i);
               end
            end
            ans.last = 1'b1;
            timer_answers_due.push_back(ans);
         end
         OP_FREE: begin
            if (idx < SLOT_CNT) slot_state[idx] = SLOT_FREE;
         end
         OP_BIND: begin
            if (idx < SLOT_CNT && q < QUEUE_IDS) begin
               slot_queue[idx] = q;
               slot_byte[idx]  = d;
               slot_bound[idx] = 1'b1;
            end
         end
         OP_ARM: begin
            if (idx < SLOT_CNT) begin
               new_due         = tick_now + delay;
               slot_due[idx]   = new_due;
               slot_state[idx] = SLOT_ARMED;
               if (earliest_due > new_due) earliest_due = new_due;
            end
         end
         OP_TICK: begin
            tick_now = tick_now + 1'b1;
            if (earliest_due <= tick_now) begin
               // fire every due slot in index order, keep the minimum of the rest
               next_due = ALL_ONES;
               for (int i = 0; i < SLOT_CNT; i++) begin
                  if (slot_state[i] == SLOT_ARMED) begin
                     if (slot_due[i] <= tick_now) begin
                        slot_state[i] = SLOT_ALLOC;
                        fired.push_back(i);
                     end else if (next_due > slot_due[i]) begin
                        next_due = slot_due[i];
                     end
                  end
               end
               earliest_due = next_due;
               foreach (fired[k]) begin
                  ans       = '0;
                  ans.kind  = RSP_FIRED;
                  ans.index = IDX_W'(fired[k]);
                  ans.queue = slot_queue[fired[k]];
                  ans.data  = slot_byte[fired[k]];
                  ans.last  = (k == fired.size() - 1);
                  timer_answers_due.push_back(ans);
               end
            end
         end
         default: ;
      endcase
   endtask

   // offer one request word after a random gap, hold it until accepted
   task automatic send_timer_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic [QID_W-1:0] q, input logic [BYTE_W-1:0] d,
                                input logic [TICK_W-1:0] delay);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, delay, d, q, idx};
      do @(posedge clock); while (!req_tready);
      apply_timer_op(op, idx, q, d, delay);
   endtask

   // stop offering and wait until every predicted word has come back
   task automatic wait_for_answers();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (timer_answers_due.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // edges of the fields, every op, firing, re-arming, wrapped deadlines
   task automatic test_directed_ops();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_timer_op(OP_ALLOC, '0, '0, '0, '0);
      send_timer_op(OP_ALLOC, '0, '0, '0, '0);
      send_timer_op(OP_BIND, 5'd0, '1, '1, '0);
      send_timer_op(OP_BIND, 5'd1, '0, '0, '0);
      send_timer_op(OP_ARM, 5'd0, '0, '0, '0);
      send_timer_op(OP_ARM, 5'd1, '0, '0, ALL_ONES);
      send_timer_op(OP_TICK, '0, '0, '0, '0);
      send_timer_op(OP_TICK, '0, '0, '0, '0);
      // free an armed slot
      send_timer_op(OP_FREE, 5'd1, '0, '0, '0);
      send_timer_op(OP_RSVD5, '1, '1, '1, ALL_ONES);
      send_timer_op(OP_RSVD6, '0, '0, '0, '0);
      send_timer_op(OP_RSVD7, '1, '1, '1, ALL_ONES);
      // top slot, re-arm of an armed slot
      send_timer_op(OP_BIND, 5'd31, 4'd10, 8'h5A, '0);
      send_timer_op(OP_ARM, 5'd31, '0, '0, 32'd1);
      send_timer_op(OP_ARM, 5'd0, '0, '0, 32'd1);
      send_timer_op(OP_ARM, 5'd31, '0, '0, 32'd6);
      send_timer_op(OP_TICK, '0, '0, '0, '0);
      // deadline wraps below the current count; later slots 0 and 31 fall due together
      send_timer_op(OP_ARM, 5'd0, '0, '0, ALL_ONES);
      send_timer_op(OP_TICK, '0, '0, '0, '0);
      send_timer_op(OP_ARM, 5'd0, '0, '0, 32'd4);
      repeat (4) send_timer_op(OP_TICK, '0, '0, '0, '0);
      send_timer_op(OP_FREE, 5'd0, '0, '0, '0);
      wait_for_answers();
   endtask

   // allocate until the table is full, then twice more
   task automatic test_table_exhaustion();
      bit any_free;
      send_idle_pct  = 13;
      recv_stall_pct = 13;
      forever begin
         any_free = 1'b0;
         foreach (slot_state[i]) if (slot_state[i] == SLOT_FREE) any_free = 1'b1;
         if (!any_free) break;
         send_timer_op(OP_ALLOC, '0, '0, '0, '0);
         if ($urandom_range(3) == 0)
            send_timer_op(OP_BIND, IDX_W'($urandom_range(SLOT_CNT - 1)),
                          QID_W'($urandom), BYTE_W'($urandom), '0);
      end
      repeat (2) send_timer_op(OP_ALLOC, '0, '0, '0, '0);
      repeat (6) send_timer_op(OP_FREE, IDX_W'($urandom_range(SLOT_CNT - 1)), '0, '0, '0);
      wait_for_answers();
   endtask

   // every slot fires on one tick while the result side holds off
   task automatic test_fire_burst_under_hold_off();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < SLOT_CNT; i++)
         send_timer_op(OP_BIND, IDX_W'(i), QID_W'($urandom), BYTE_W'($urandom), '0);
      for (int i = 0; i < SLOT_CNT; i++)
         send_timer_op(OP_ARM, IDX_W'(i), '0, '0, 32'd1);
      hold_toggle <= ~hold_toggle;
      send_timer_op(OP_TICK, '0, '0, '0, '0);
      repeat (8) send_timer_op(OP_ALLOC, '0, '0, '0, '0);
      wait_for_answers();
      repeat (10) send_timer_op(OP_FREE, IDX_W'($urandom_range(SLOT_CNT - 1)), '0, '0, '0);
   endtask

   // random mix of ops; arms only reach slots that have been bound
   task automatic test_random_traffic(input int send_pct, input int stall_pct, input int words);
      int                pick;
      logic [IDX_W-1:0]  slot;
      logic [TICK_W-1:0] delay;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      repeat (words) begin
         pick = $urandom_range(99);
         slot = IDX_W'($urandom_range(SLOT_CNT - 1));
         case ($urandom_range(9))
            0, 1:    delay = $urandom;
            2:       delay = ALL_ONES - $urandom_range(3);
            default: delay = $urandom_range(6);
         endcase
         if (pick < 14)
            send_timer_op(OP_ALLOC, '0, '0, '0, '0);
         else if (pick < 24)
            send_timer_op(OP_FREE, slot, '0, '0, '0);
         else if (pick < 42 || (pick < 68 && !slot_bound[slot]))
            send_timer_op(OP_BIND, slot, QID_W'($urandom), BYTE_W'($urandom), '0);
         else if (pick < 68)
            send_timer_op(OP_ARM, slot, '0, '0, delay);
         else if (pick < 97)
            send_timer_op(OP_TICK, '0, '0, '0, '0);
         else
            send_timer_op(OP_RSVD5 + OP_W'($urandom_range(2)), slot, QID_W'($urandom),
                          BYTE_W'($urandom), $urandom);
      end
      wait_for_answers();
   endtask

   // result side: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_left  <= HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      timer_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (timer_answers_due.size() == 0) begin
            $error("unexpected result word: kind %0d, index %0d", rsp_tuser, rsp_tdata[4:0]);
            failures++;
         end else begin
            want = timer_answers_due.pop_front();
            compare_field("kind", want.kind, rsp_tuser);
            compare_field("out_index", want.index, rsp_tdata[4:0]);
            compare_field("alloc_ok", want.ok, rsp_tdata[5]);
            compare_field("out_queue", want.queue, rsp_tdata[9:6]);
            compare_field("out_data", want.data, rsp_tdata[17:10]);
            compare_field("last", want.last, rsp_tlast);
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      tick_now     = '0;
      earliest_due = ALL_ONES;
      foreach (slot_state[i]) begin
         slot_state[i] = SLOT_FREE;
         slot_due[i]   = '0;
         slot_queue[i] = '0;
         slot_byte[i]  = '0;
         slot_bound[i] = 1'b0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed_ops();
      test_table_exhaustion();
      test_fire_burst_under_hold_off();
      test_random_traffic(0, 0, 32);
      test_random_traffic(45, 0, 32);
      test_random_traffic(0, 45, 32);
      test_random_traffic(13, 13, 32);

      wait_for_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
